FILE: design/bat_pkg.sv
package bat_pkg;

	localparam int ID_W     = 16;
	localparam int STATUS_W = 3;
	localparam int TOL_W    = 12;
	localparam int DIMS_W   = 4;
	localparam int DIMI_W   = 3;
	localparam int CFG_IW   = 1;
	localparam int CFG_DW   = 12;

	localparam logic [CFG_IW-1:0] REG_TOLERANCE = 1'd0;
	localparam logic [CFG_IW-1:0] REG_DIMS      = 1'd1;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_NEIGHBOR  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

	localparam logic [TOL_W-1:0]  TOL_RESET  = 12'd4;
	localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd7;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REMOVE,
		S_CHECK,
		S_SCAN
	} state_t;

	// one cell's share of the neighbor scan chain
	typedef struct packed {
		logic            hit;
		logic [ID_W-1:0] id;
	} scan_t;

	// control broadcast to every cell
	typedef struct packed {
		logic store;   // lowest free cell takes the pending box
		logic remove;  // matching cell drops its box
		logic load;    // capture hit flags into the scan chain
		logic shift;   // advance the scan chain by one cell
	} cell_ctrl_t;

endpackage

FILE: design/box_adjacency_table.sv
// Box adjacency table. Issue a word with start while busy is low; each
// result appears on neighbor_id/status/last for one cycle with strobe high
// and must be taken then, the block never waits for the receiver. An add
// word for a dimension other than the last in use (or beyond it) is taken
// while the block stays idle and gives nothing. A remove gives one result
// the cycle after it is taken. A completing add passes through a check
// state (duplicate, full, and every slot's contact test at once, all
// dimensions in parallel), then the hit flags ride a chain of slot cells
// toward cell 0, one cell per cycle, and the neighbor list ends at the
// last hit; results come in ascending slot order. Config writes (wr_en,
// wr_index, wr_data) take effect at once and belong in idle time only.
// No clearing pass follows reset.
module box_adjacency_table #(
	parameter int MAX_BOXES  = 32,
	parameter int MAX_DIMS   = 8,
	parameter int COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              command,
	input  logic [bat_pkg::ID_W-1:0]          box_id,
	input  logic [bat_pkg::DIMI_W-1:0]        dim_index,
	input  logic signed [COORD_BITS-1:0]      low_edge,
	input  logic signed [COORD_BITS-1:0]      high_edge,
	output logic                              strobe,
	output logic [bat_pkg::ID_W-1:0]          neighbor_id,
	output logic [bat_pkg::STATUS_W-1:0]      status,
	output logic                              last,
	input  logic                              wr_en,
	input  logic [bat_pkg::CFG_IW-1:0]        wr_index,
	input  logic [bat_pkg::CFG_DW-1:0]        wr_data
);

	localparam int NW    = $clog2(MAX_DIMS + 1);
	localparam int DIMIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	bat_pkg::state_t                     state_q, state_d;
	logic [bat_pkg::TOL_W-1:0]           tol_q;
	logic [bat_pkg::DIMS_W-1:0]          dims_q;
	logic [bat_pkg::ID_W-1:0]            id_q;
	logic [MAX_DIMS-1:0][COORD_BITS-1:0] pend_low_q;
	logic [MAX_DIMS-1:0][COORD_BITS-1:0] pend_high_q;
	logic [NW-1:0]                       n_eff;
	logic [DIMIW-1:0]                    widx;
	logic                                accept;
	logic                                dim_ok;
	logic                                dim_final;

	bat_pkg::cell_ctrl_t                 ctrl;
	logic [MAX_BOXES:0]                  none_free;
	logic [MAX_BOXES-1:0]                id_match;
	logic [MAX_BOXES-1:0]                hit_now;
	bat_pkg::scan_t                      scan [MAX_BOXES+1];
	logic [MAX_BOXES-1:0]                rest_hits;

	logic any_match;
	logic any_hit;
	logic full;
	logic rest_any;

	always_comb begin
		if (dims_q == '0) n_eff = NW'(1);
		else if (int'(dims_q) > MAX_DIMS) n_eff = NW'(MAX_DIMS);
		else n_eff = NW'(dims_q);
	end

	assign accept    = start && !busy;
	assign widx      = DIMIW'(dim_index);
	assign dim_ok    = int'(dim_index) < int'(n_eff);
	assign dim_final = int'(dim_index) == int'(n_eff) - 1;
	assign busy      = (state_q != bat_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= bat_pkg::TOL_RESET;
			dims_q <= bat_pkg::DIMS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				bat_pkg::REG_TOLERANCE: tol_q  <= wr_data[bat_pkg::TOL_W-1:0];
				bat_pkg::REG_DIMS:      dims_q <= wr_data[bat_pkg::DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	// pending box: one interval per add word
	always_ff @(posedge clk) begin
		if (accept && command == bat_pkg::CMD_ADD && dim_ok) begin
			pend_low_q[widx]  <= low_edge;
			pend_high_q[widx] <= high_edge;
		end
		if (accept) begin
			id_q <= box_id;
		end
	end

	// slot cells
	assign none_free[0]    = 1'b1;
	assign scan[MAX_BOXES] = '0;

	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
		bat_cell #(
			.MAX_DIMS   (MAX_DIMS),
			.COORD_BITS (COORD_BITS),
			.NW         (NW)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.key_id        (id_q),
			.new_low       (pend_low_q),
			.new_high      (pend_high_q),
			.n_eff         (n_eff),
			.tol           (tol_q),
			.none_free_in  (none_free[i]),
			.none_free_out (none_free[i+1]),
			.id_match      (id_match[i]),
			.hit_now       (hit_now[i]),
			.scan_in       (scan[i+1]),
			.scan_out      (scan[i])
		);
		assign rest_hits[i] = (i > 0) ? scan[i].hit : 1'b0;
	end

	assign any_match = |id_match;
	assign any_hit   = |hit_now;
	assign full      = none_free[MAX_BOXES];
	assign rest_any  = |rest_hits;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bat_pkg::S_IDLE: begin
				if (accept) begin
					if (command == bat_pkg::CMD_REMOVE) state_d = bat_pkg::S_REMOVE;
					else if (dim_ok && dim_final) state_d = bat_pkg::S_CHECK;
				end
			end
			bat_pkg::S_REMOVE: state_d = bat_pkg::S_IDLE;
			bat_pkg::S_CHECK: begin
				if (!any_match && !full && any_hit) state_d = bat_pkg::S_SCAN;
				else state_d = bat_pkg::S_IDLE;
			end
			bat_pkg::S_SCAN: begin
				if (!rest_any) state_d = bat_pkg::S_IDLE;
			end
			default: state_d = bat_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// outputs and cell control
	always_comb begin
		ctrl        = '0;
		strobe      = 1'b0;
		neighbor_id = '0;
		status      = bat_pkg::ST_NEIGHBOR;
		last        = 1'b0;
		case (state_q)
			bat_pkg::S_REMOVE: begin
				ctrl.remove = 1'b1;
				strobe      = 1'b1;
				last        = 1'b1;
				status      = any_match ? bat_pkg::ST_REMOVED : bat_pkg::ST_NOT_FOUND;
			end
			bat_pkg::S_CHECK: begin
				if (any_match) begin
					strobe = 1'b1;
					last   = 1'b1;
					status = bat_pkg::ST_DUPLICATE;
				end else if (full) begin
					strobe = 1'b1;
					last   = 1'b1;
					status = bat_pkg::ST_FULL;
				end else begin
					ctrl.store = 1'b1;
					ctrl.load  = 1'b1;
					if (!any_hit) begin
						strobe = 1'b1;
						last   = 1'b1;
						status = bat_pkg::ST_ADDED;
					end
				end
			end
			bat_pkg::S_SCAN: begin
				ctrl.shift = 1'b1;
				if (scan[0].hit) begin
					strobe      = 1'b1;
					neighbor_id = scan[0].id;
					last        = !rest_any;
				end
			end
			default: ;
		endcase
	end

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result outside a command");

	a_remove_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == bat_pkg::CMD_REMOVE) |=>
		(strobe && last && (status == bat_pkg::ST_REMOVED || status == bat_pkg::ST_NOT_FOUND)))
		else $error("remove gave no answer");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !busy) else $error("busy after final result");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> busy) else $error("neighbor list cut short");

	a_neighbor_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == bat_pkg::ST_NEIGHBOR) |-> (state_q == bat_pkg::S_SCAN))
		else $error("neighbor result outside scan");

endmodule

FILE: design/bat_cell.sv
module bat_cell #(
	parameter int MAX_DIMS   = 8,
	parameter int COORD_BITS = 16,
	parameter int NW         = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bat_pkg::cell_ctrl_t                  ctrl,
	input  logic [bat_pkg::ID_W-1:0]             key_id,
	input  logic [MAX_DIMS-1:0][COORD_BITS-1:0]  new_low,
	input  logic [MAX_DIMS-1:0][COORD_BITS-1:0]  new_high,
	input  logic [NW-1:0]                        n_eff,
	input  logic [bat_pkg::TOL_W-1:0]            tol,
	input  logic                                 none_free_in,
	output logic                                 none_free_out,
	output logic                                 id_match,
	output logic                                 hit_now,
	input  bat_pkg::scan_t                       scan_in,
	output bat_pkg::scan_t                       scan_out
);

	localparam int OW = ((COORD_BITS + 1 > bat_pkg::TOL_W + 1) ?
		COORD_BITS + 1 : bat_pkg::TOL_W + 1) + 1;

	logic                                valid_q;
	logic [bat_pkg::ID_W-1:0]            id_q;
	logic [MAX_DIMS-1:0][COORD_BITS-1:0] low_q;
	logic [MAX_DIMS-1:0][COORD_BITS-1:0] high_q;
	bat_pkg::scan_t                      scan_q;
	logic                                take;
	logic                                touch;

	assign take          = none_free_in & ~valid_q;
	assign none_free_out = none_free_in & valid_q;
	assign id_match      = valid_q && (id_q == key_id);
	assign hit_now       = valid_q & touch;
	assign scan_out      = scan_q;

	// dimensions in use side by side: any far-apart axis rejects, else any close one touches
	always_comb begin
		logic signed [COORD_BITS-1:0] hi;
		logic signed [COORD_BITS-1:0] lo;
		logic signed [OW-1:0]         ov;
		logic signed [OW-1:0]         tol_x;
		logic                         apart;
		logic                         close;
		apart = 1'b0;
		close = 1'b0;
		tol_x = signed'(OW'(tol));
		for (int d = 0; d < MAX_DIMS; d++) begin
			hi = ($signed(new_high[d]) < $signed(high_q[d])) ? new_high[d] : high_q[d];
			lo = ($signed(new_low[d]) > $signed(low_q[d])) ? new_low[d] : low_q[d];
			ov = OW'(hi) - OW'(lo);
			if (d < int'(n_eff)) begin
				if (ov < -tol_x) apart = 1'b1;
				if (ov <= tol_x) close = 1'b1;
			end
		end
		touch = close & ~apart;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.store && take) begin
			valid_q <= 1'b1;
		end else if (ctrl.remove && id_match) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.store && take) begin
			id_q   <= key_id;
			low_q  <= new_low;
			high_q <= new_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (ctrl.load) begin
			scan_q.hit <= hit_now;
			scan_q.id  <= id_q;
		end else if (ctrl.shift) begin
			scan_q <= scan_in;
		end
	end

endmodule
